// ===== rtl/core/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by spq_ctrl, spq_datapath and sorted_priority_queue_top; no dependencies.
package spq_pkg;

   // Default number of stored pairs
   localparam int CAPACITY_DEFAULT = 16;

   // Field widths fixed by the request and response formats
   localparam int VALUE_W     = 32;
   localparam int PRIORITY_W  = 32;
   localparam int STATUS_W    = 2;
   localparam int OCCUPANCY_W = 5;

   // Request operation codes
   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // register the incoming request
      logic execute;   // apply the held request and load the response
   } spq_cmd_type;

endpackage

// ===== rtl/core/spq_ctrl.sv =====
// Controller state machine for the sorted priority queue.
// Depends on spq_pkg; drives the handshake and commands spq_datapath.
module spq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output spq_pkg::spq_cmd_type cmd
);
   import spq_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // Hold state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequence one request: capture, then execute once the output slot is free
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.execute  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   // An accepted request always moves the controller into execution
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_EXEC))
      else $error("spq_ctrl: accepted request did not enter execution");

   // A response is never loaded over one that is still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> (!rsp_valid_ff || !rsp_stall))
      else $error("spq_ctrl: response overwritten while stalled");

   // Capture and execute never coincide
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("spq_ctrl: capture and execute asserted together");
`endif

endmodule

// ===== rtl/core/spq_datapath.sv =====
// Datapath for the sorted priority queue: request register, sorted slot row
// with parallel compare and shift, entry count and response register. Uses spq_pkg.
module spq_datapath #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  spq_pkg::spq_cmd_type                  cmd,
   input  logic                                  req_opcode,
   input  logic signed [spq_pkg::VALUE_W-1:0]    req_item_value,
   input  logic signed [spq_pkg::PRIORITY_W-1:0] req_item_priority,
   output logic signed [spq_pkg::VALUE_W-1:0]    rsp_out_value,
   output logic [spq_pkg::STATUS_W-1:0]          rsp_status,
   output logic [spq_pkg::OCCUPANCY_W-1:0]       rsp_occupancy
);
   import spq_pkg::*;

   localparam int CntW = $clog2(CAPACITY + 1);

   // Held request
   logic                         op_ff;
   logic signed [VALUE_W-1:0]    val_ff;
   logic signed [PRIORITY_W-1:0] prio_ff;

   // Sorted slot row, ascending priority from slot 0
   logic signed [VALUE_W-1:0]    slot_val_ff  [CAPACITY];
   logic signed [PRIORITY_W-1:0] slot_prio_ff [CAPACITY];
   logic signed [VALUE_W-1:0]    slot_val_in  [CAPACITY];
   logic signed [PRIORITY_W-1:0] slot_prio_in [CAPACITY];

   // Neighbor views of each slot
   logic signed [VALUE_W-1:0]    prev_val  [CAPACITY];
   logic signed [PRIORITY_W-1:0] prev_prio [CAPACITY];
   logic signed [VALUE_W-1:0]    next_val  [CAPACITY];
   logic signed [PRIORITY_W-1:0] next_prio [CAPACITY];
   logic [CAPACITY-1:0]          move;
   logic [CAPACITY-1:0]          prev_move;

   logic [CntW-1:0]        count_ff;
   logic [CntW-1:0]        count_in;
   logic                   full;
   logic                   empty;
   logic                   push_en;
   logic                   pop_en;

   logic signed [VALUE_W-1:0] out_value_ff;
   logic signed [VALUE_W-1:0] out_value_in;
   status_type                status_ff;
   status_type                status_in;
   logic [OCCUPANCY_W-1:0]    occupancy_ff;

   // Capture the request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         val_ff  <= req_item_value;
         prio_ff <= req_item_priority;
      end
   end

   assign full    = (count_ff >= CntW'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign push_en = cmd.execute && (op_ff == OP_INSERT) && !full;
   assign pop_en  = cmd.execute && (op_ff == OP_EXTRACT) && !empty;

   // Per-slot compare: a slot moves up if it is unused or ranks after the new pair
   for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
      assign move[i] = (count_ff <= CntW'(i)) || (slot_prio_ff[i] > prio_ff);
      if (i == 0) begin : g_first
         assign prev_move[i] = 1'b0;
         assign prev_val[i]  = slot_val_ff[i];
         assign prev_prio[i] = slot_prio_ff[i];
      end else begin : g_rest
         assign prev_move[i] = move[i-1];
         assign prev_val[i]  = slot_val_ff[i-1];
         assign prev_prio[i] = slot_prio_ff[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_val[i]  = slot_val_ff[i];
         assign next_prio[i] = slot_prio_ff[i];
      end else begin : g_inner
         assign next_val[i]  = slot_val_ff[i+1];
         assign next_prio[i] = slot_prio_ff[i+1];
      end
   end

   // Shift up behind the insert point, drop the new pair in, or shift down on extract
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         slot_val_in[i]  = slot_val_ff[i];
         slot_prio_in[i] = slot_prio_ff[i];
         if (push_en) begin
            if (prev_move[i]) begin
               slot_val_in[i]  = prev_val[i];
               slot_prio_in[i] = prev_prio[i];
            end else if (move[i]) begin
               slot_val_in[i]  = val_ff;
               slot_prio_in[i] = prio_ff;
            end
         end else if (pop_en) begin
            slot_val_in[i]  = next_val[i];
            slot_prio_in[i] = next_prio[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         slot_val_ff[i]  <= slot_val_in[i];
         slot_prio_ff[i] <= slot_prio_in[i];
      end
   end

   // Update the count and form the response
   always_comb begin
      count_in     = count_ff;
      out_value_in = '0;
      status_in    = STATUS_OK;
      if (push_en) begin
         count_in = count_ff + CntW'(1);
      end else if (pop_en) begin
         count_in     = count_ff - CntW'(1);
         out_value_in = slot_val_ff[0];
      end else if (op_ff == OP_INSERT) begin
         status_in = STATUS_FULL;
      end else begin
         status_in = STATUS_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   // Hold the response until the next execute
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         out_value_ff <= out_value_in;
         status_ff    <= status_in;
         occupancy_ff <= OCCUPANCY_W'(count_in);
      end
   end

   assign rsp_out_value = out_value_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = occupancy_ff;

`ifndef SYNTH
   // The count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(CAPACITY))
      else $error("spq_datapath: entry count above capacity");

   // A refused or empty operation leaves the count alone
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && !push_en && !pop_en) |=> $stable(count_ff))
      else $error("spq_datapath: count changed on refused operation");

   // The two head slots stay in priority order
   a_head_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CntW'(2)) |-> (slot_prio_ff[0] <= slot_prio_ff[1]))
      else $error("spq_datapath: head slots out of order");
`endif

endmodule

// ===== rtl/core/sorted_priority_queue_top.sv =====
// Sorted priority queue: keeps up to CAPACITY value/priority pairs in ascending
// priority order; an insert lands behind every pair of equal or lower priority,
// so equal priorities leave first in, first out. Each request is first registered,
// then applied by a compare-and-shift across every slot at once; a new request is
// accepted only after the previous one has executed. The next request is taken
// while a response still waits in the output register; a second response waits
// only if that one has not been taken. An insert into a full queue returns
// status 1 and stores nothing; an extract from an empty queue returns value 0
// and status 2. Occupancy carries the low five bits of the count. Depends on
// spq_pkg, spq_ctrl and spq_datapath.
module sorted_priority_queue_top #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_opcode,
   input  logic signed [spq_pkg::VALUE_W-1:0]    req_item_value,
   input  logic signed [spq_pkg::PRIORITY_W-1:0] req_item_priority,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [spq_pkg::VALUE_W-1:0]    rsp_out_value,
   output logic [spq_pkg::STATUS_W-1:0]          rsp_status,
   output logic [spq_pkg::OCCUPANCY_W-1:0]       rsp_occupancy
);
   import spq_pkg::*;

   spq_cmd_type cmd;

   // Sequence requests
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Store, sort and answer
   spq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_opcode        (req_opcode),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_out_value     (rsp_out_value),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy)
   );

`ifndef SYNTH
   // A refused insert reports a full queue
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |-> (rsp_occupancy == OCCUPANCY_W'(CAPACITY)))
      else $error("sorted_priority_queue_top: full status with wrong occupancy");

   // An empty extract reports zero value and zero occupancy
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |->
      (rsp_occupancy == '0 && rsp_out_value == '0))
      else $error("sorted_priority_queue_top: empty status with nonzero fields");

   // No request is accepted in the cycle after one was accepted
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("sorted_priority_queue_top: back-to-back request accepted");
`endif

endmodule

// ===== sim/tb_sorted_priority_queue_top.sv =====
// Self-checking testbench for sorted_priority_queue_top: directed and random requests,
// each response checked against a local sorted-queue predictor.
// Depends on spq_pkg and the sorted_priority_queue_top RTL.
module tb_sorted_priority_queue_top;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH   = CAPACITY_DEFAULT;
   localparam int DRAIN_CYCLES  = 20;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic signed [VALUE_W-1:0]   value;
      status_type                  status;
      logic [OCCUPANCY_W-1:0]      occupancy;
   } queue_response_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_opcode = OP_INSERT;
   logic signed [VALUE_W-1:0]     req_item_value = '0;
   logic signed [PRIORITY_W-1:0]  req_item_priority = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0]     rsp_out_value;
   logic [STATUS_W-1:0]           rsp_status;
   logic [OCCUPANCY_W-1:0]        rsp_occupancy;

   // Predictor state: stored pairs in ascending priority order
   logic signed [VALUE_W-1:0]     stored_value [QUEUE_DEPTH];
   logic signed [PRIORITY_W-1:0]  stored_priority [QUEUE_DEPTH];
   int                            stored_count = 0;

   queue_response_type            expected_responses [$];
   queue_response_type            oldest_expected;
   logic                          idling_on = 1'b1;
   int                            error_count = 0;
   int                            mismatch_count = 0;
   int                            inserts_sent = 0;
   int                            extracts_sent = 0;
   int                            full_refusals_seen = 0;
   int                            empty_extracts_seen = 0;
   int                            responses_checked = 0;

   sorted_priority_queue_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_value     (rsp_out_value),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apply one request to the predictor and return the response it should give
   function automatic queue_response_type predict_response(
      input logic                         op,
      input logic signed [VALUE_W-1:0]    val,
      input logic signed [PRIORITY_W-1:0] prio
   );
      queue_response_type r;
      int                 pos;
      int                 k;
      r.value  = '0;
      r.status = STATUS_OK;
      if (op == OP_INSERT) begin
         if (stored_count >= QUEUE_DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            // land behind every pair of equal or lower priority
            pos = stored_count;
            while (pos > 0 && stored_priority[pos-1] > prio) pos--;
            for (k = stored_count; k > pos; k--) begin
               stored_value[k]    = stored_value[k-1];
               stored_priority[k] = stored_priority[k-1];
            end
            stored_value[pos]    = val;
            stored_priority[pos] = prio;
            stored_count++;
         end
      end else begin
         if (stored_count == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            // pop the head and shift the rest down
            r.value = stored_value[0];
            for (k = 0; k + 1 < stored_count; k++) begin
               stored_value[k]    = stored_value[k+1];
               stored_priority[k] = stored_priority[k+1];
            end
            stored_count--;
         end
      end
      r.occupancy = OCCUPANCY_W'(stored_count);
      return r;
   endfunction

   // Drive one request, hold it until accepted, then record its expected response
   task automatic send_request(
      input logic                         op,
      input logic signed [VALUE_W-1:0]    val,
      input logic signed [PRIORITY_W-1:0] prio
   );
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_item_value    <= val;
      req_item_priority <= prio;
      do @(posedge clock); while (req_stall);
      expected_responses.push_back(predict_response(op, val, prio));
      if (op == OP_INSERT) inserts_sent++;
      else extracts_sent++;
   endtask

   // Stall the response side in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_checked++;
         if (rsp_status == STATUS_FULL) full_refusals_seen++;
         if (rsp_status == STATUS_EMPTY) empty_extracts_seen++;
         if (expected_responses.size() == 0) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("ERROR: response with none expected: value=%h status=%0d occ=%0d",
                        rsp_out_value, rsp_status, rsp_occupancy);
         end else begin
            oldest_expected = expected_responses.pop_front();
            if (rsp_out_value !== oldest_expected.value ||
                rsp_status !== oldest_expected.status ||
                rsp_occupancy !== oldest_expected.occupancy) begin
               error_count++;
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"ERROR: response %0d: exp value=%h status=%0d occ=%0d, ",
                            "got value=%h status=%0d occ=%0d"},
                           responses_checked, oldest_expected.value,
                           oldest_expected.status, oldest_expected.occupancy,
                           rsp_out_value, rsp_status, rsp_occupancy);
            end
         end
      end
   end

   // Extract from an empty queue; value and priority fields must be ignored
   task automatic test_empty_extract();
      send_request(OP_EXTRACT, 32'h5A5A_A5A5, 32'hDEAD_BEEF);
   endtask

   // Insert the priority extremes out of order, then take the two lowest
   task automatic test_extreme_priorities();
      send_request(OP_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(OP_INSERT, 32'h8000_0000, 32'h8000_0000);
      send_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
      send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_EXTRACT, '0, '0);
      send_request(OP_EXTRACT, '1, '1);
   endtask

   // Fill with tied priorities to check arrival order, then insert into a full queue
   task automatic test_ties_and_full();
      int i;
      for (i = 0; i < QUEUE_DEPTH - 2; i++)
         send_request(OP_INSERT, 32'h1000_0000 + i, (i % 3) - 1);
      send_request(OP_INSERT, 32'h1234_5678, 32'h8000_0000);
      send_request(OP_EXTRACT, '0, '0);
      send_request(OP_EXTRACT, '0, '0);
   endtask

   // Random mix of requests, biased toward filling or draining by insert_pct
   task automatic test_random_traffic(input int n_items, input int insert_pct);
      int                        i;
      logic                      op;
      logic signed [VALUE_W-1:0] val;
      logic signed [PRIORITY_W-1:0] prio;
      for (i = 0; i < n_items; i++) begin
         op  = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_EXTRACT;
         val = $urandom;
         // favor a narrow priority band so ties are frequent
         case ($urandom_range(0, 3))
            0, 1:    prio = int'($urandom_range(0, 8)) - 4;
            2:       prio = $urandom;
            default: prio = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF - $urandom_range(0, 2)
                                                        : 32'h8000_0000 + $urandom_range(0, 2);
         endcase
         send_request(op, val, prio);
      end
   endtask

   initial begin
      int phase;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_empty_extract();
      test_extreme_priorities();
      test_ties_and_full();
      for (phase = 0; phase < 16; phase++) begin
         case (phase % 3)
            0:       test_random_traffic(50, 25);
            1:       test_random_traffic(50, 75);
            default: test_random_traffic(50, 50);
         endcase
      end
      // finish at full rate with no idling on either side
      idling_on = 1'b0;
      test_random_traffic(150, 55);
      req_valid <= 1'b0;

      while (expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d inserts and %0d extracts, %0d responses checked.",
               inserts_sent, extracts_sent, responses_checked);
      $display("Saw %0d full-queue refusals and %0d empty-queue extracts, %0d mismatches.",
               full_refusals_seen, empty_extracts_seen, mismatch_count);
      if (error_count == 0) begin
         $display("tb_sorted_priority_queue_top: PASS");
      end else begin
         $display("tb_sorted_priority_queue_top: FAIL");
      end
      $finish;
   end

   // Abort a hung run
   initial begin
      #400000;
      $display("tb_sorted_priority_queue_top: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_ctrl.sv
rtl/core/spq_datapath.sv
rtl/core/sorted_priority_queue_top.sv
sim/tb_sorted_priority_queue_top.sv
